// ===== rtl/core/mersenne_twister_generator_unit_macros.svh =====
// Assertion macros shared by the generator RTL
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MTG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mtg_pkg.sv =====
// Types, constants and tempering function of the MT19937 generator
package mtg_pkg;

   localparam int WORD_W = 32;
   localparam int IDX_W  = 10;
   localparam int CSR_IDX_W = 1;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam int TABLE_N  = 624;
   localparam int TABLE_M  = 397;
   localparam int TABLE_NM = 227;

   localparam idx_type  POS_FULL     = idx_type'(TABLE_N);
   localparam idx_type  POS_UNSEEDED = idx_type'(TABLE_N + 1);

   localparam word_type INIT_MULT    = 32'd1812433253;
   localparam word_type DEFAULT_SEED = 32'd5489;
   localparam word_type TEMPER_B     = 32'h9D2C5680;
   localparam word_type TEMPER_C     = 32'hEFC60000;

   localparam word_type XOR_EVEN_RESET = 32'h00000000;
   localparam word_type XOR_ODD_RESET  = 32'h9908B0DF;

   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam csr_idx_type CSR_TWIST_XOR_EVEN = 1'b0;
   localparam csr_idx_type CSR_TWIST_XOR_ODD  = 1'b1;

   function automatic word_type temper(input word_type y_in);
      word_type y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== rtl/core/mtg_req_if.sv =====
// Request channel: command and seed word
interface mtg_req_if;
   import mtg_pkg::*;

   logic     valid;
   logic     ready;
   logic     command;
   word_type seed_value;

   modport source (output valid, output command, output seed_value, input ready);
   modport sink   (input valid, input command, input seed_value, output ready);
endinterface

// ===== rtl/core/mtg_rsp_if.sv =====
// Response channel: tempered random word
interface mtg_rsp_if;
   import mtg_pkg::*;

   logic     valid;
   logic     ready;
   word_type random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/core/mtg_ram.sv =====
// Generic RAM: one write port, two registered read ports
module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/core/mersenne_twister_generator_unit.sv =====
// Top level of the MT19937 generator: seed fill, lazy per-word twist, tempering
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    command, seed_value
//   rsp      out  valid/ready    random_word
//   csr      in   write_enable   csr_index, csr_write_data
//
// Draw: both RAM read ports fetch the twist operands as the request is accepted,
// then twist, temper and write-back of the word happen together in ST_TWIST.
// Seed: the seed is written to word 0 on acceptance, then a multiply step and an add step per further table word.
// Draw with no prior seed: default seed fill, then the draw.
// Reset is synchronous; the table position starts at "never seeded".
// A result waits in the output register; the next transaction is still
// accepted, and a draw holds in its twist cycle until the register frees.
`include "mersenne_twister_generator_unit_macros.svh"

module mersenne_twister_generator_unit (
   input  logic                 clock,
   input  logic                 reset,
   mtg_req_if.sink              req_chan,
   mtg_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  mtg_pkg::csr_idx_type csr_index,
   input  mtg_pkg::word_type    csr_write_data
);
   import mtg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_MUL,
      ST_FILL_ADD,
      ST_ISSUE,
      ST_TWIST
   } state_type;

   state_type state_ff, state_in;
   idx_type   pos_ff, pos_in;
   idx_type   draw_idx_ff, draw_idx_in;
   idx_type   fill_idx_ff, fill_idx_in;
   word_type  fill_prev_ff, fill_prev_in;
   word_type  fill_prod_ff, fill_prod_in;
   logic      hi_bit_ff, hi_bit_in;
   logic      pending_draw_ff, pending_draw_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_word_ff, rsp_word_in;
   word_type  xor_even_ff, xor_even_in;
   word_type  xor_odd_ff, xor_odd_in;
   word_type  gen_even_ff, gen_even_in;
   word_type  gen_odd_ff, gen_odd_in;

   logic     req_accept;
   logic     seed_start;
   logic     out_free;
   idx_type  cur_idx;
   word_type fill_mix;
   word_type fill_sum;
   word_type twist_y;
   word_type twisted;

   logic     ram_we;
   idx_type  ram_wr_addr;
   word_type ram_wr_data;
   logic     ram_re;
   idx_type  ram_rd_addr_a;
   idx_type  ram_rd_addr_b;
   word_type ram_rd_data_a;
   word_type ram_rd_data_b;

   mtg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_N)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_re),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.random_word = rsp_word_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign seed_start = req_accept &&
                       (req_chan.command == CMD_SEED || pos_ff == POS_UNSEEDED);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // position 624 wraps to word 0 of a new generation
   assign cur_idx  = (pos_ff >= POS_FULL) ? '0 : pos_ff;
   assign fill_mix = fill_prev_ff ^ (fill_prev_ff >> 30);
   assign fill_sum = fill_prod_ff + word_type'(fill_idx_ff);

   // hi bit of word k is cached from the previous draw's port-a read of word k
   assign twist_y = {hi_bit_ff, ram_rd_data_a[WORD_W-2:0]};
   assign twisted = ram_rd_data_b ^ (twist_y >> 1) ^
                    (twist_y[0] ? gen_odd_ff : gen_even_ff);

   always_comb begin
      ram_re        = (req_accept && req_chan.command == CMD_DRAW &&
                       pos_ff != POS_UNSEEDED) || (state_ff == ST_ISSUE);
      ram_rd_addr_a = (cur_idx == idx_type'(TABLE_N - 1)) ? '0 : cur_idx + idx_type'(1);
      ram_rd_addr_b = (cur_idx < idx_type'(TABLE_NM)) ? cur_idx + idx_type'(TABLE_M)
                                                      : cur_idx - idx_type'(TABLE_NM);
      ram_we      = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = (req_chan.command == CMD_SEED) ? req_chan.seed_value : DEFAULT_SEED;
      if (seed_start) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_FILL_ADD) begin
         ram_we      = 1'b1;
         ram_wr_addr = fill_idx_ff;
         ram_wr_data = fill_sum;
      end else if (state_ff == ST_TWIST) begin
         ram_we      = out_free;
         ram_wr_addr = draw_idx_ff;
         ram_wr_data = twisted;
      end
   end

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      draw_idx_in     = ram_re ? cur_idx : draw_idx_ff;
      fill_idx_in     = fill_idx_ff;
      fill_prev_in    = fill_prev_ff;
      fill_prod_in    = fill_prod_ff;
      hi_bit_in       = hi_bit_ff;
      pending_draw_in = pending_draw_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in     = rsp_word_ff;
      xor_even_in     = xor_even_ff;
      xor_odd_in      = xor_odd_ff;
      gen_even_in     = gen_even_ff;
      gen_odd_in      = gen_odd_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_TWIST_XOR_EVEN: xor_even_in = csr_write_data;
            CSR_TWIST_XOR_ODD:  xor_odd_in  = csr_write_data;
            default: ;
         endcase
      end

      // twist words stay fixed for a whole table generation
      if (ram_re && pos_ff >= POS_FULL) begin
         gen_even_in = xor_even_ff;
         gen_odd_in  = xor_odd_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (seed_start) begin
               fill_prev_in    = ram_wr_data;
               fill_idx_in     = idx_type'(1);
               hi_bit_in       = ram_wr_data[WORD_W-1];
               pending_draw_in = (req_chan.command == CMD_DRAW);
               state_in        = ST_FILL_MUL;
            end else if (req_accept) begin
               state_in = ST_TWIST;
            end
         end
         ST_FILL_MUL: begin
            fill_prod_in = word_type'(INIT_MULT * fill_mix);
            state_in     = ST_FILL_ADD;
         end
         ST_FILL_ADD: begin
            fill_prev_in = fill_sum;
            fill_idx_in  = fill_idx_ff + idx_type'(1);
            if (fill_idx_ff == idx_type'(TABLE_N - 1)) begin
               pos_in   = POS_FULL;
               state_in = pending_draw_ff ? ST_ISSUE : ST_IDLE;
            end else begin
               state_in = ST_FILL_MUL;
            end
         end
         ST_ISSUE: begin
            pending_draw_in = 1'b0;
            state_in        = ST_TWIST;
         end
         ST_TWIST: begin
            if (out_free) begin
               hi_bit_in    = ram_rd_data_a[WORD_W-1];
               pos_in       = draw_idx_ff + idx_type'(1);
               rsp_valid_in = 1'b1;
               rsp_word_in  = temper(twisted);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= POS_UNSEEDED;
         pending_draw_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         xor_even_ff     <= XOR_EVEN_RESET;
         xor_odd_ff      <= XOR_ODD_RESET;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         pending_draw_ff <= pending_draw_in;
         rsp_valid_ff    <= rsp_valid_in;
         xor_even_ff     <= xor_even_in;
         xor_odd_ff      <= xor_odd_in;
      end
      draw_idx_ff  <= draw_idx_in;
      fill_idx_ff  <= fill_idx_in;
      fill_prev_ff <= fill_prev_in;
      fill_prod_ff <= fill_prod_in;
      hi_bit_ff    <= hi_bit_in;
      rsp_word_ff  <= rsp_word_in;
      gen_even_ff  <= gen_even_in;
      gen_odd_ff   <= gen_odd_in;
   end

   `MTG_ASSERT_IMPLY(a_no_rw_overlap, clock, reset, ram_we && ram_re, ram_wr_addr != ram_rd_addr_a && ram_wr_addr != ram_rd_addr_b, "table read and write hit the same word")
   `MTG_ASSERT_IMPLY(a_rsp_from_twist, clock, reset, !rsp_valid_ff && rsp_valid_in, state_ff == ST_TWIST, "response raised outside the twist cycle")
   `MTG_ASSERT_NEXT(a_fill_end_pos, clock, reset, state_ff == ST_FILL_ADD && fill_idx_ff == idx_type'(TABLE_N - 1), pos_ff == POS_FULL, "fill did not leave the position at table end")
   `MTG_ASSERT_IMPLY(a_twist_idx, clock, reset, state_ff == ST_TWIST, draw_idx_ff < POS_FULL, "twist index outside the table")

endmodule
